[rtl/mos_alu_pkg.sv]
// ----------------------------------------------------------------------------
// mos_alu_pkg
// Shared types and operation codes for the 6502 register execute unit.
// ----------------------------------------------------------------------------
package mos_alu_pkg;

    localparam int unsigned FUNC_W = 6;
    localparam int unsigned DATA_W = 8;

    localparam logic [FUNC_W-1:0] FN_ADC = 6'd0;
    localparam logic [FUNC_W-1:0] FN_SBC = 6'd1;
    localparam logic [FUNC_W-1:0] FN_AND = 6'd2;
    localparam logic [FUNC_W-1:0] FN_ORA = 6'd3;
    localparam logic [FUNC_W-1:0] FN_EOR = 6'd4;
    localparam logic [FUNC_W-1:0] FN_CMP = 6'd5;
    localparam logic [FUNC_W-1:0] FN_CPX = 6'd6;
    localparam logic [FUNC_W-1:0] FN_CPY = 6'd7;
    localparam logic [FUNC_W-1:0] FN_BIT = 6'd8;
    localparam logic [FUNC_W-1:0] FN_ASL = 6'd9;
    localparam logic [FUNC_W-1:0] FN_LSR = 6'd10;
    localparam logic [FUNC_W-1:0] FN_ROL = 6'd11;
    localparam logic [FUNC_W-1:0] FN_ROR = 6'd12;
    localparam logic [FUNC_W-1:0] FN_INC = 6'd13;
    localparam logic [FUNC_W-1:0] FN_DEC = 6'd14;
    localparam logic [FUNC_W-1:0] FN_LDA = 6'd15;
    localparam logic [FUNC_W-1:0] FN_LDX = 6'd16;
    localparam logic [FUNC_W-1:0] FN_LDY = 6'd17;
    localparam logic [FUNC_W-1:0] FN_INX = 6'd18;
    localparam logic [FUNC_W-1:0] FN_INY = 6'd19;
    localparam logic [FUNC_W-1:0] FN_DEX = 6'd20;
    localparam logic [FUNC_W-1:0] FN_DEY = 6'd21;
    localparam logic [FUNC_W-1:0] FN_TAX = 6'd22;
    localparam logic [FUNC_W-1:0] FN_TAY = 6'd23;
    localparam logic [FUNC_W-1:0] FN_TXA = 6'd24;
    localparam logic [FUNC_W-1:0] FN_TYA = 6'd25;
    localparam logic [FUNC_W-1:0] FN_CLC = 6'd26;
    localparam logic [FUNC_W-1:0] FN_SEC = 6'd27;
    localparam logic [FUNC_W-1:0] FN_CLD = 6'd28;
    localparam logic [FUNC_W-1:0] FN_SED = 6'd29;
    localparam logic [FUNC_W-1:0] FN_CLV = 6'd30;
    localparam logic [FUNC_W-1:0] FN_CLI = 6'd31;
    localparam logic [FUNC_W-1:0] FN_SEI = 6'd32;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] operand;
        logic              on_accumulator;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] write_value;
        logic              write_memory;
        logic [DATA_W-1:0] acc_out;
        logic [DATA_W-1:0] x_out;
        logic [DATA_W-1:0] y_out;
        logic              neg_out;
        logic              ovf_out;
        logic              zero_out;
        logic              carry_out;
        logic              dec_out;
        logic              irq_mask_out;
    } t_out_word;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] xreg;
        logic [DATA_W-1:0] yreg;
        logic              n;
        logic              v;
        logic              z;
        logic              c;
        logic              d;
        logic              i;
    } t_cpu_state;

endpackage

[rtl/mos_alu_exec.sv]
// ----------------------------------------------------------------------------
// mos_alu_exec
// Single-pass data operation: next registers, flags and memory write-back.
// ----------------------------------------------------------------------------
module mos_alu_exec (
    input  mos_alu_pkg::t_in_word   i_word,
    input  mos_alu_pkg::t_cpu_state i_state,
    output mos_alu_pkg::t_cpu_state o_state,
    output logic [7:0]              o_write_value,
    output logic                    o_write_memory
);

    logic [7:0] m;
    logic [7:0] src;
    logic [9:0] add_bin;
    logic [9:0] add_dl;
    logic [9:0] add_dec;
    logic       bw;
    logic [7:0] diff;
    logic       sbc_v;
    logic       sbc_c;
    logic [4:0] al0;
    logic [4:0] ah0;
    logic [4:0] al1;
    logic [4:0] ah1;
    logic [4:0] ah2;
    logic [7:0] sub_dec;
    logic [7:0] cmp_a;
    logic [7:0] cmp_x;
    logic [7:0] cmp_y;
    logic [7:0] sh_val;
    logic       sh_c;
    logic       is_shift;
    logic [7:0] nz_val;
    logic       set_nz;
    mos_alu_pkg::t_cpu_state s;

    assign m   = i_word.operand;
    assign src = i_word.on_accumulator ? i_state.acc : m;

    assign add_bin = 10'(i_state.acc) + 10'(m) + 10'(i_state.c);
    assign add_dl  = (add_bin[3:0] > 4'd9) ? add_bin + 10'h006 : add_bin;
    assign add_dec = (add_dl[7:4] > 4'h9) ? add_dl + 10'h060 : add_dl;

    assign bw    = ~i_state.c;
    assign diff  = i_state.acc - m - 8'(bw);
    assign sbc_v = (i_state.acc[7] ^ m[7]) & (i_state.acc[7] ^ diff[7]);
    assign sbc_c = {1'b0, i_state.acc} >= (9'(m) + 9'(bw));

    assign al0 = 5'(i_state.acc[3:0]) - 5'(m[3:0]) - 5'(bw);
    assign ah0 = 5'(i_state.acc[7:4]) - 5'(m[7:4]);
    assign al1 = al0[4] ? al0 - 5'd6 : al0;
    assign ah1 = al0[4] ? ah0 - 5'd1 : ah0;
    assign ah2 = ah1[4] ? ah1 - 5'd6 : ah1;
    assign sub_dec = {ah2[3:0], al1[3:0]};

    assign cmp_a = i_state.acc - m;
    assign cmp_x = i_state.xreg - m;
    assign cmp_y = i_state.yreg - m;

    always_comb begin
        s              = i_state;
        o_write_value  = 8'h00;
        o_write_memory = 1'b0;
        sh_val         = 8'h00;
        sh_c           = 1'b0;
        is_shift       = 1'b0;
        nz_val         = 8'h00;
        set_nz         = 1'b0;
        case (i_word.func)
            mos_alu_pkg::FN_ADC: begin
                if (i_state.d) begin
                    s.acc = add_dec[7:0];
                    s.c   = |add_dec[9:8];
                end else begin
                    s.acc = add_bin[7:0];
                    s.c   = add_bin[8];
                    s.v   = ~(i_state.acc[7] ^ m[7]) & (i_state.acc[7] ^ add_bin[7]);
                end
                nz_val = s.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_SBC: begin
                if (i_state.d) begin
                    s.acc = sub_dec;
                    s.c   = ~ah1[4];
                end else begin
                    s.acc = diff;
                    s.c   = sbc_c;
                end
                s.v    = sbc_v;
                nz_val = s.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_AND: begin
                s.acc  = i_state.acc & m;
                nz_val = s.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_ORA: begin
                s.acc  = i_state.acc | m;
                nz_val = s.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_EOR: begin
                s.acc  = i_state.acc ^ m;
                nz_val = s.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_CMP: begin
                s.c    = i_state.acc >= m;
                nz_val = cmp_a;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_CPX: begin
                s.c    = i_state.xreg >= m;
                nz_val = cmp_x;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_CPY: begin
                s.c    = i_state.yreg >= m;
                nz_val = cmp_y;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_BIT: begin
                s.z = ~|(i_state.acc & m);
                s.n = m[7];
                s.v = m[6];
            end
            mos_alu_pkg::FN_ASL: begin
                sh_val   = {src[6:0], 1'b0};
                sh_c     = src[7];
                is_shift = 1'b1;
            end
            mos_alu_pkg::FN_LSR: begin
                sh_val   = {1'b0, src[7:1]};
                sh_c     = src[0];
                is_shift = 1'b1;
            end
            mos_alu_pkg::FN_ROL: begin
                sh_val   = {src[6:0], i_state.c};
                sh_c     = src[7];
                is_shift = 1'b1;
            end
            mos_alu_pkg::FN_ROR: begin
                sh_val   = {i_state.c, src[7:1]};
                sh_c     = src[0];
                is_shift = 1'b1;
            end
            mos_alu_pkg::FN_INC: begin
                o_write_value  = m + 8'd1;
                o_write_memory = 1'b1;
                nz_val         = o_write_value;
                set_nz         = 1'b1;
            end
            mos_alu_pkg::FN_DEC: begin
                o_write_value  = m - 8'd1;
                o_write_memory = 1'b1;
                nz_val         = o_write_value;
                set_nz         = 1'b1;
            end
            mos_alu_pkg::FN_LDA: begin
                s.acc  = m;
                nz_val = m;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_LDX: begin
                s.xreg = m;
                nz_val = m;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_LDY: begin
                s.yreg = m;
                nz_val = m;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_INX: begin
                s.xreg = i_state.xreg + 8'd1;
                nz_val = s.xreg;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_INY: begin
                s.yreg = i_state.yreg + 8'd1;
                nz_val = s.yreg;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_DEX: begin
                s.xreg = i_state.xreg - 8'd1;
                nz_val = s.xreg;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_DEY: begin
                s.yreg = i_state.yreg - 8'd1;
                nz_val = s.yreg;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_TAX: begin
                s.xreg = i_state.acc;
                nz_val = i_state.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_TAY: begin
                s.yreg = i_state.acc;
                nz_val = i_state.acc;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_TXA: begin
                s.acc  = i_state.xreg;
                nz_val = i_state.xreg;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_TYA: begin
                s.acc  = i_state.yreg;
                nz_val = i_state.yreg;
                set_nz = 1'b1;
            end
            mos_alu_pkg::FN_CLC: s.c = 1'b0;
            mos_alu_pkg::FN_SEC: s.c = 1'b1;
            mos_alu_pkg::FN_CLD: s.d = 1'b0;
            mos_alu_pkg::FN_SED: s.d = 1'b1;
            mos_alu_pkg::FN_CLV: s.v = 1'b0;
            mos_alu_pkg::FN_CLI: s.i = 1'b0;
            mos_alu_pkg::FN_SEI: s.i = 1'b1;
            default: begin
                s = i_state;
            end
        endcase

        if (is_shift) begin
            s.c    = sh_c;
            nz_val = sh_val;
            set_nz = 1'b1;
            if (i_word.on_accumulator) begin
                s.acc = sh_val;
            end else begin
                o_write_value  = sh_val;
                o_write_memory = 1'b1;
            end
        end

        if (set_nz) begin
            s.n = nz_val[7];
            s.z = ~|nz_val;
        end
        o_state = s;
    end

endmodule

[rtl/mos6502_alu_register_execute.sv]
// ----------------------------------------------------------------------------
// mos6502_alu_register_execute
// 6502 data operation unit with kept A, X, Y and N V Z C D I flags.
//
//   channel  direction  handshake              word
//   in       input      i_in_valid/o_in_stall  mos_alu_pkg::t_in_word
//   out      output     o_out_valid/i_out_stall mos_alu_pkg::t_out_word
//
// One word per cycle sustained while the output is not stalled.
// The input register feeds the execute logic, which writes the result
// register and the architectural state in the same edge.
// Reset clears A, X, Y, all flags and both valid bits.
// An output stall holds the result, then the input register, then o_in_stall.
// ----------------------------------------------------------------------------
module mos6502_alu_register_execute (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mos_alu_pkg::t_in_word  i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mos_alu_pkg::t_out_word o_out_word
);

    logic                    r_in_valid;
    mos_alu_pkg::t_in_word   r_in_word;
    logic                    r_out_valid;
    mos_alu_pkg::t_out_word  r_out_word;
    mos_alu_pkg::t_cpu_state r_state;

    logic                    advance;
    logic                    exec;
    mos_alu_pkg::t_cpu_state n_state;
    mos_alu_pkg::t_out_word  n_out_word;
    logic [7:0]              wr_value;
    logic                    wr_memory;

    mos_alu_exec u_exec (
        .i_word         (r_in_word),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_write_value  (wr_value),
        .o_write_memory (wr_memory)
    );

    assign advance    = ~r_out_valid | ~i_out_stall;
    assign exec       = r_in_valid & advance;
    assign o_in_stall = r_in_valid & ~advance;

    always_comb begin
        n_out_word.write_value  = wr_value;
        n_out_word.write_memory = wr_memory;
        n_out_word.acc_out      = n_state.acc;
        n_out_word.x_out        = n_state.xreg;
        n_out_word.y_out        = n_state.yreg;
        n_out_word.neg_out      = n_state.n;
        n_out_word.ovf_out      = n_state.v;
        n_out_word.zero_out     = n_state.z;
        n_out_word.carry_out    = n_state.c;
        n_out_word.dec_out      = n_state.d;
        n_out_word.irq_mask_out = n_state.i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (exec) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
        if (exec) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input word dropped while stalled");

    a_state_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_out_valid && r_state.acc == r_out_word.acc_out
            && r_state.xreg == r_out_word.x_out && r_state.yreg == r_out_word.y_out
            && r_state.c == r_out_word.carry_out && r_state.z == r_out_word.zero_out)
        else $error("kept state differs from reported result");

    a_state_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> $stable(r_state))
        else $error("state changed without an executed word");

    a_dec_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && r_in_word.func != mos_alu_pkg::FN_CLD
            && r_in_word.func != mos_alu_pkg::FN_SED |=> $stable(r_state.d))
        else $error("decimal flag changed by a non flag operation");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.write_memory |-> o_out_word.write_value == 8'h00)
        else $error("write value set without memory write");

endmodule
